>>> sv/tqlu_pkg.sv
// -----------------------------------------------------------------------------
// tqlu_pkg: shared types and constants of the Q-learning update engine
// Holds opcodes, reward codes, sequencer states and datapath widths.
// -----------------------------------------------------------------------------
package tqlu_pkg;

   localparam int Q_W      = 16;  // Q8.8 entry width
   localparam int COEF_W   = 9;   // Q1.8 coefficient, 256 means one
   localparam int TD_W     = 18;  // temporal difference range
   localparam int PROD_W   = 28;  // coefficient times difference
   localparam int RND_W    = PROD_W - 8;

   localparam logic [COEF_W-1:0] COEF_ONE = 9'd256;

   // rewards in Q8.8: +1.0 and -5.0
   localparam logic signed [TD_W-1:0] REWARD_CLOSER  = 18'sd256;
   localparam logic signed [TD_W-1:0] REWARD_FARTHER = -18'sd1280;

   localparam logic REG_LEARNING_RATE = 1'b0;
   localparam logic REG_DISCOUNT      = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_LEARN = 2'd1,
      OP_BEST  = 2'd2,
      OP_RSVD  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      RS_NONE    = 2'd0,
      RS_CLOSER  = 2'd1,
      RS_FARTHER = 2'd2
   } reward_sign_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_NS,
      ST_READ_Q,
      ST_MUL_G,
      ST_TD,
      ST_MUL_A,
      ST_WRITE,
      ST_SCAN_S,
      ST_SCAN_END,
      ST_RESP
   } state_type;

   // control of the shared multiply unit
   typedef struct packed {
      logic mul_en;     // load product register
      logic sel_alpha;  // alpha * td instead of gamma * max
      logic td_en;      // load temporal difference register
   } upd_ctrl_type;

endpackage

>>> sv/tqlu_upd.sv
// -----------------------------------------------------------------------------
// tqlu_upd: shared multiplier and update arithmetic
// One multiplier serves gamma*max and then alpha*td; rounds, adds, saturates.
// -----------------------------------------------------------------------------
module tqlu_upd
   import tqlu_pkg::*;
(
   input  logic                     clock,
   input  upd_ctrl_type             ctrl,
   input  logic        [COEF_W-1:0] alpha,
   input  logic        [COEF_W-1:0] gamma,
   input  logic signed [Q_W-1:0]    row_max,
   input  logic signed [Q_W-1:0]    cur_q,
   input  logic signed [TD_W-1:0]   reward,
   output logic signed [Q_W-1:0]    new_q
);

   logic signed [COEF_W:0]   coef_s;
   logic signed [TD_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_bias;
   logic signed [RND_W-1:0]  rnd;
   logic signed [RND_W-1:0]  td_full;
   logic signed [TD_W-1:0]   td_in;
   logic signed [TD_W-1:0]   td_ff;
   logic signed [RND_W:0]    sum;

   assign coef_s  = $signed({1'b0, (ctrl.sel_alpha ? alpha : gamma)});
   assign mul_b   = ctrl.sel_alpha ? td_ff : TD_W'(row_max);
   assign prod_in = coef_s * mul_b;

   // round half up: add half an LSB, keep the upper bits
   assign prod_bias = prod_ff + PROD_W'(128);
   assign rnd       = prod_bias[PROD_W-1:8];

   assign td_full = RND_W'(reward) + rnd - RND_W'(cur_q);
   assign td_in   = td_full[TD_W-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.td_en) begin
         td_ff <= td_in;
      end
   end

   assign sum = (RND_W + 1)'(cur_q) + (RND_W + 1)'(rnd);

   always_comb begin
      if (sum > (RND_W + 1)'(32767)) begin
         new_q = 16'sh7FFF;
      end else if (sum < -(RND_W + 1)'(32768)) begin
         new_q = -16'sh8000;
      end else begin
         new_q = sum[Q_W-1:0];
      end
   end

endmodule

>>> sv/tabular_q_learning_update.sv
// -----------------------------------------------------------------------------
// tabular_q_learning_update: Q table with learning step and best-action lookup
// Keeps a table of Q8.8 action values, applies the Q-learning update on
// request and reports the best action of a row.
// -----------------------------------------------------------------------------
//
//  Channel  Direction  Beat contents
//  req_     in         tuser: opcode[1:0]; tdata: state_index, action_index,
//                      next_state, entry_value, target_distance, target_present
//  rsp_     out        tdata: best_action, result_value, reward_sign
//  csr_     in         write only: csr_index selects learning_rate / discount
//
//  Sequence: one beat at a time. Learning step with target: scan of the next-state
//  row, read of the entry, multiply, difference, multiply, write, then scan of the
//  addressed row, all through the single table port. Write entry: write, then scan.
//  Best action or step without target: scan. Ignored request: straight to response.
//  The sequencer returns to idle after each response before taking the next request.
//  Reset: control, coefficients and last distance reset at once; table contents
//  are undefined until written, there is no clearing pass.
//  Stalls: a finished response waits in the output register; the next request
//  is taken meanwhile, and its response holds in the final state until rsp_tready.
//
module tabular_q_learning_update
   import tqlu_pkg::*;
#(
   parameter int NUM_STATES  = 64,
   parameter int NUM_ACTIONS = 8
)
(
   input  logic        clock,
   input  logic        reset,
   // slave side
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] state_index, [8:6] action_index, [14:9] next_state,
   // [30:15] entry_value, [46:31] target_distance, [47] target_present
   input  logic [47:0] req_tdata,
   // [1:0] opcode
   input  logic [1:0]  req_tuser,
   // master side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] best_action, [18:3] result_value, [20:19] reward_sign, [23:21] zero
   output logic [23:0] rsp_tdata,
   // configuration
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int SW    = $clog2(NUM_STATES);
   localparam int AW    = $clog2(NUM_ACTIONS);
   localparam int SXW   = (SW > 6) ? SW : 6;
   localparam int AXW   = (AW > 3) ? AW : 3;
   localparam int DEPTH = NUM_STATES << AW;
   localparam logic [AW-1:0] LAST_COL = AW'(NUM_ACTIONS - 1);

   // ---------------------------------------------------------------------------
   // Unpack the request beat
   // ---------------------------------------------------------------------------
   logic [5:0]      in_state;
   logic [2:0]      in_action;
   logic [5:0]      in_next;
   logic [Q_W-1:0]  in_value;
   logic [15:0]     in_dist;
   logic            in_present;
   op_type          in_op;
   logic [SXW-1:0]  s_ext;
   logic [SXW-1:0]  ns_ext;
   logic [AXW-1:0]  a_ext;
   logic            in_range;
   logic            req_acc;
   logic            learn_go;
   logic            closer;

   assign in_state   = req_tdata[5:0];
   assign in_action  = req_tdata[8:6];
   assign in_next    = req_tdata[14:9];
   assign in_value   = req_tdata[30:15];
   assign in_dist    = req_tdata[46:31];
   assign in_present = req_tdata[47];
   assign in_op      = op_type'(req_tuser);

   assign s_ext  = SXW'(in_state);
   assign ns_ext = SXW'(in_next);
   assign a_ext  = AXW'(in_action);

   assign in_range = (32'(in_state) < NUM_STATES) && (32'(in_next) < NUM_STATES) &&
                     (32'(in_action) < NUM_ACTIONS) && (in_op != OP_RSVD);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [AW-1:0]      col_ff, col_in;
   op_type             op_ff;
   logic [SW-1:0]      s_row_ff, ns_row_ff;
   logic [AW-1:0]      a_col_ff;
   logic [Q_W-1:0]     value_ff;
   reward_sign_type    sign_ff;
   logic               zero_ff;
   logic [15:0]        last_dist_ff;
   logic [COEF_W-1:0]  alpha_ff, gamma_ff;

   logic               rd_scan_ff, rd_cap_ff;
   logic [AW-1:0]      rd_col_ff;
   logic [Q_W-1:0]     rd_data_ff;
   logic signed [Q_W-1:0] best_val_ff, best_val_in;
   logic [AW-1:0]      best_idx_ff, best_idx_in;
   logic signed [Q_W-1:0] cur_q_ff, cur_q_in;

   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]         rsp_best_ff;
   logic [Q_W-1:0]     rsp_value_ff;
   reward_sign_type    rsp_sign_ff;

   // sequencer outputs
   logic               rd_en, rd_scan, rd_cap, wr_en, rsp_load;
   logic               use_ns_row, use_a_col;
   upd_ctrl_type       upd_ctrl;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign closer     = in_dist < last_dist_ff;
   assign learn_go   = req_acc && in_range && (in_op == OP_LEARN) && in_present;

   // ---------------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      col_in     = col_ff;
      rd_en      = 1'b0;
      rd_scan    = 1'b0;
      rd_cap     = 1'b0;
      wr_en      = 1'b0;
      rsp_load   = 1'b0;
      use_ns_row = 1'b0;
      use_a_col  = 1'b0;
      upd_ctrl   = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (!in_range) begin
                  state_in = ST_RESP;
               end else if (in_op == OP_WRITE) begin
                  state_in = ST_WRITE;
               end else if (learn_go) begin
                  state_in = ST_SCAN_NS;
               end else begin
                  state_in = ST_SCAN_S;
               end
            end
         end
         ST_SCAN_NS: begin
            // walk the next-state row for its maximum
            rd_en      = 1'b1;
            rd_scan    = 1'b1;
            use_ns_row = 1'b1;
            if (col_ff == LAST_COL) begin
               col_in   = '0;
               state_in = ST_READ_Q;
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
         ST_READ_Q: begin
            rd_en     = 1'b1;
            rd_cap    = 1'b1;
            use_a_col = 1'b1;
            state_in  = ST_MUL_G;
         end
         ST_MUL_G: begin
            upd_ctrl.mul_en = 1'b1;
            state_in        = ST_TD;
         end
         ST_TD: begin
            upd_ctrl.td_en = 1'b1;
            state_in       = ST_MUL_A;
         end
         ST_MUL_A: begin
            upd_ctrl.mul_en    = 1'b1;
            upd_ctrl.sel_alpha = 1'b1;
            state_in           = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en     = 1'b1;
            use_a_col = 1'b1;
            state_in  = ST_SCAN_S;
         end
         ST_SCAN_S: begin
            // walk the addressed row: argmax and the entry itself
            rd_en   = 1'b1;
            rd_scan = 1'b1;
            rd_cap  = (col_ff == a_col_ff);
            if (col_ff == LAST_COL) begin
               col_in   = '0;
               state_in = ST_SCAN_END;
            end else begin
               col_in = col_ff + AW'(1);
            end
         end
         ST_SCAN_END: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Request capture, last distance and coefficients
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff     <= in_op;
         s_row_ff  <= s_ext[SW-1:0];
         ns_row_ff <= ns_ext[SW-1:0];
         a_col_ff  <= a_ext[AW-1:0];
         value_ff  <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_ff      <= 1'b0;
         sign_ff      <= RS_NONE;
         last_dist_ff <= '1;
         alpha_ff     <= 9'd26;
         gamma_ff     <= 9'd230;
      end else begin
         if (req_acc) begin
            zero_ff <= !in_range;
            sign_ff <= learn_go ? (closer ? RS_CLOSER : RS_FARTHER) : RS_NONE;
         end
         // store the distance either way once a step runs
         if (learn_go) begin
            last_dist_ff <= in_dist;
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_LEARNING_RATE: alpha_ff <= csr_wdata;
               REG_DISCOUNT:      gamma_ff <= csr_wdata;
               default:           ;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Q table: one port, registered read
   // ---------------------------------------------------------------------------
   logic [Q_W-1:0]      q_mem [DEPTH];
   logic [SW+AW-1:0]    mem_addr;
   logic signed [Q_W-1:0] new_q;
   logic [Q_W-1:0]      wr_data;

   assign mem_addr = {(use_ns_row ? ns_row_ff : s_row_ff), (use_a_col ? a_col_ff : col_ff)};
   assign wr_data  = (op_ff == OP_WRITE) ? value_ff : new_q;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_mem[mem_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= q_mem[mem_addr];
      end
      rd_col_ff <= col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_scan_ff <= 1'b0;
         rd_cap_ff  <= 1'b0;
      end else begin
         rd_scan_ff <= rd_scan;
         rd_cap_ff  <= rd_cap;
      end
   end

   // running maximum over a row, lowest column wins ties
   always_comb begin
      best_val_in = best_val_ff;
      best_idx_in = best_idx_ff;
      cur_q_in    = cur_q_ff;
      if (rd_scan_ff) begin
         if ((rd_col_ff == '0) || ($signed(rd_data_ff) > best_val_ff)) begin
            best_val_in = $signed(rd_data_ff);
            best_idx_in = rd_col_ff;
         end
      end
      if (rd_cap_ff) begin
         cur_q_in = $signed(rd_data_ff);
      end
   end

   always_ff @(posedge clock) begin
      best_val_ff <= best_val_in;
      best_idx_ff <= best_idx_in;
      cur_q_ff    <= cur_q_in;
   end

   // ---------------------------------------------------------------------------
   // Shared update arithmetic
   // ---------------------------------------------------------------------------
   logic [COEF_W-1:0]      alpha_c, gamma_c;
   logic signed [TD_W-1:0] reward;

   // coefficients above one act as one
   assign alpha_c = (alpha_ff > COEF_ONE) ? COEF_ONE : alpha_ff;
   assign gamma_c = (gamma_ff > COEF_ONE) ? COEF_ONE : gamma_ff;
   assign reward  = (sign_ff == RS_CLOSER) ? REWARD_CLOSER : REWARD_FARTHER;

   tqlu_upd u_upd (
      .clock   (clock),
      .ctrl    (upd_ctrl),
      .alpha   (alpha_c),
      .gamma   (gamma_c),
      .row_max (best_val_ff),
      .cur_q   (cur_q_ff),
      .reward  (reward),
      .new_q   (new_q)
   );

   // ---------------------------------------------------------------------------
   // Response register
   // ---------------------------------------------------------------------------
   logic [AXW-1:0] best_ext;

   assign best_ext = AXW'(best_idx_ff);

   always_comb begin
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_best_ff  <= zero_ff ? 3'd0 : best_ext[2:0];
         rsp_value_ff <= zero_ff ? '0 : cur_q_ff;
         rsp_sign_ff  <= zero_ff ? RS_NONE : sign_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {3'd0, rsp_sign_ff, rsp_value_ff, rsp_best_ff};

`ifndef NO_ASSERTIONS
   // table port is never read and written in one cycle
   a_port_exclusive: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("table read and write in the same cycle");

   // a new request never lands on a read still in flight
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> !(rd_scan_ff || rd_cap_ff))
      else $error("request accepted while a table read is pending");

   // a learning step always stores the new distance
   a_last_dist: assert property (@(posedge clock) disable iff (reset)
      learn_go |=> (last_dist_ff == $past(in_dist)))
      else $error("last distance not updated by learning step");

   // a response appears only out of the response state
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == ST_RESP))
      else $error("response raised outside the response state");

   // column counter is parked between requests
   a_col_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (col_ff == '0))
      else $error("scan counter not cleared in idle");
`endif

endmodule
